@@ rtl/fud_pkg.sv @@
package fud_pkg;

   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_0       = 8'h30;
   localparam logic [7:0] CHAR_9       = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;

   localparam int MAX_BYTES = 3;

   // One queue entry: the decoded bytes caused by one input beat, in order.
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [1:0]                count;
      logic                      last;
   } fud_entry_type;

   // Head of the queue as seen by the back end.
   typedef struct packed {
      logic          valid;
      fud_entry_type entry;
   } fud_head_type;

   typedef struct packed {
      logic       is_hex;
      logic [3:0] value;
   } fud_hex_type;

   function automatic fud_hex_type hex_digit(input logic [7:0] c);
      fud_hex_type r;
      logic [7:0]  d;
      r.is_hex = 1'b0;
      r.value  = 4'd0;
      d        = 8'd0;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         d        = c - CHAR_0;
         r.is_hex = 1'b1;
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         d        = c - CHAR_UPPER_A + 8'd10;
         r.is_hex = 1'b1;
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
         d        = c - CHAR_LOWER_A + 8'd10;
         r.is_hex = 1'b1;
      end
      r.value = d[3:0];
      return r;
   endfunction

endpackage

@@ rtl/fud_front.sv @@
module fud_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [7:0]             req_in_byte,
   input  logic                   req_in_last,
   input  logic                   queue_full,
   output logic                   push,
   output fud_pkg::fud_entry_type push_entry
);
   import fud_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PCT,
      ST_DIGIT
   } state_type;

   state_type   state_ff, state_in;
   logic [7:0]  held_ff, held_in;
   fud_hex_type c_hex, h_hex;
   logic        accept;
   logic        idle_hold;
   logic [7:0]  idle_val;

   assign accept = req_valid && !queue_full;
   assign c_hex  = hex_digit(req_in_byte);
   assign h_hex  = hex_digit(held_ff);

   // A percent sign in plain text opens an escape unless the string ends on it.
   assign idle_hold = (req_in_byte == CHAR_PERCENT) && !req_in_last;
   assign idle_val  = (req_in_byte == CHAR_PLUS) ? CHAR_SPACE : req_in_byte;

   always_comb begin
      push_entry       = '0;
      push_entry.last  = req_in_last;
      state_in         = ST_IDLE;
      held_in          = held_ff;
      case (state_ff)
         ST_PCT: begin
            if (c_hex.is_hex) begin
               if (req_in_last) begin
                  push_entry.bytes[0] = CHAR_PERCENT;
                  push_entry.bytes[1] = req_in_byte;
                  push_entry.count    = 2'd2;
               end else begin
                  state_in = ST_DIGIT;
                  held_in  = req_in_byte;
               end
            end else begin
               push_entry.bytes[0] = CHAR_PERCENT;
               if (idle_hold) begin
                  push_entry.count = 2'd1;
                  state_in         = ST_PCT;
               end else begin
                  push_entry.bytes[1] = idle_val;
                  push_entry.count    = 2'd2;
               end
            end
         end
         ST_DIGIT: begin
            if (c_hex.is_hex) begin
               push_entry.bytes[0] = {h_hex.value, c_hex.value};
               push_entry.count    = 2'd1;
            end else begin
               // The held digit is always a hex character, so it passes as is.
               push_entry.bytes[0] = CHAR_PERCENT;
               push_entry.bytes[1] = held_ff;
               if (idle_hold) begin
                  push_entry.count = 2'd2;
                  state_in         = ST_PCT;
               end else begin
                  push_entry.bytes[2] = idle_val;
                  push_entry.count    = 2'd3;
               end
            end
         end
         default: begin
            if (idle_hold) begin
               state_in = ST_PCT;
            end else begin
               push_entry.bytes[0] = idle_val;
               push_entry.count    = 2'd1;
            end
         end
      endcase
      if (req_in_last) begin
         state_in = ST_IDLE;
         held_in  = 8'd0;
      end
   end

   assign push = accept && (push_entry.count != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

endmodule

@@ rtl/fud_queue.sv @@
module fud_queue #(
   parameter int DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  fud_pkg::fud_entry_type push_entry,
   input  logic                   pop,
   output logic                   full,
   output fud_pkg::fud_head_type  head
);
   import fud_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   fud_entry_type    mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ rtl/fud_back.sv @@
module fud_back (
   input  logic                  clock,
   input  logic                  reset,
   input  fud_pkg::fud_head_type head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_run_last,
   output logic                  rsp_string_end
);
   import fud_pkg::*;

   logic [1:0] sel_ff, sel_in;
   logic       final_byte;
   logic       beat;

   assign final_byte     = ((sel_ff + 2'd1) == head.entry.count);
   assign beat           = head.valid && !rsp_stall;

   assign rsp_valid      = head.valid;
   assign rsp_out_byte   = head.entry.bytes[sel_ff];
   assign rsp_run_last   = final_byte;
   assign rsp_string_end = final_byte && head.entry.last;

   // The entry leaves the queue together with its last byte.
   assign pop    = beat && final_byte;
   assign sel_in = final_byte ? 2'd0 : sel_ff + 2'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 2'd0;
      end else if (beat) begin
         sel_ff <= sel_in;
      end
   end

endmodule

@@ rtl/form_url_decoder_unit.sv @@
// Streaming form-urlencoded decoder. One byte of text is taken per beat on the
// req_ channel, with req_in_last on the final byte of a string; '+' decodes to a
// space, '%' with two hex digits to one byte, and an unfinished escape passes
// through literally. An input beat is accepted every cycle while the result
// queue (QUEUE_DEPTH entries) has room. Each beat yields zero to three decoded
// bytes; while rsp_stall is low these leave on the rsp_ channel one per cycle, the
// earliest in the cycle after the input beat; as the single output port of the back
// end sets the result rate and output never outgrows input, one input byte per cycle
// is sustained apart from short bursts that the queue absorbs. rsp_run_last marks
// the last byte caused by one input beat, rsp_string_end the last byte of a string.
module form_url_decoder_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_string_end
);
   import fud_pkg::*;

   fud_entry_type push_entry;
   fud_head_type  head;
   logic          push;
   logic          pop;
   logic          full;

   assign req_stall = full;

   fud_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .queue_full  (full),
      .push        (push),
      .push_entry  (push_entry)
   );

   fud_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .head       (head)
   );

   fud_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_string_end (rsp_string_end)
   );

endmodule

@@ rtl/fud_checker.sv @@
module fud_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_run_last,
   input logic       rsp_string_end
);

   // A stalled result beat holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_run_last) && $stable(rsp_string_end))
      else $error("result beat changed while stalled");

   // The end of a string is always the end of the run for its input beat.
   a_end_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_end |-> rsp_run_last)
      else $error("string end outside the last byte of a run");

   // Bytes of one run follow without a gap.
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_run_last |=> rsp_valid)
      else $error("run of decoded bytes broken off");

   // Reset empties the result queue.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind form_url_decoder_unit fud_checker u_fud_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_run_last   (rsp_run_last),
   .rsp_string_end (rsp_string_end)
);

@@ test/form_url_decoder_unit_test.sv @@
`timescale 1ns / 1ps

module form_url_decoder_unit_test;
   import fud_pkg::*;

   typedef struct {
      logic [7:0] text;
      logic       last;
      bit         hold_until_drained;
   } text_beat_type;

   typedef struct {
      logic [7:0] data;
      logic       run_last;
      logic       string_end;
   } decoded_byte_type;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int BURST_BEATS    = 95;
   localparam int TOTAL_BEATS    = 120;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic [7:0] req_in_byte = 8'h01;
   logic       req_in_last = 1'b0;
   logic       rsp_stall   = 1'b0;
   wire        req_stall;
   wire        rsp_valid;
   wire  [7:0] rsp_out_byte;
   wire        rsp_run_last;
   wire        rsp_string_end;

   text_beat_type    pending_beats[$];
   decoded_byte_type expected_bytes[$];
   logic [7:0]       decoded_run[$];

   // Escape decoder state, mirrored from the block.
   logic [1:0] held_count = 2'd0;
   logic [7:0] held_char  = 8'd0;

   bit bursts_on    = 1'b1;
   bit req_taken    = 1'b0;
   int req_gap      = 0;
   int rsp_gap      = 0;
   int beats_queued = 0;
   int beats_done   = 0;
   int idle_cycles  = 0;
   int failures     = 0;

   form_url_decoder_unit i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .req_in_last   (req_in_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last),
      .rsp_string_end(rsp_string_end)
   );

   always #6 clock = ~clock;

   function automatic bit is_hex_char(input logic [7:0] c);
      return (c >= CHAR_0 && c <= CHAR_9) || (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) ||
             (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F);
   endfunction

   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [7:0] d;
      if (c <= CHAR_9) begin
         d = c - CHAR_0;
      end else if (c <= CHAR_UPPER_F) begin
         d = c - CHAR_UPPER_A + 8'd10;
      end else begin
         d = c - CHAR_LOWER_A + 8'd10;
      end
      return d[3:0];
   endfunction

   // A byte seen with no escape in progress; a '%' may open a new one.
   function void decode_plain(input logic [7:0] c, input logic last);
      if (c == CHAR_PERCENT) begin
         if (last) begin
            decoded_run.push_back(CHAR_PERCENT);
         end else begin
            held_count = 2'd1;
         end
      end else if (c == CHAR_PLUS) begin
         decoded_run.push_back(CHAR_SPACE);
      end else begin
         decoded_run.push_back(c);
      end
   endfunction

   function void predict_decode(input logic [7:0] c, input logic last);
      decoded_byte_type entry;
      decoded_run.delete();
      case (held_count)
         2'd1: begin
            if (is_hex_char(c)) begin
               if (last) begin
                  decoded_run.push_back(CHAR_PERCENT);
                  decoded_run.push_back(c);
               end else begin
                  held_count = 2'd2;
                  held_char  = c;
               end
            end else begin
               decoded_run.push_back(CHAR_PERCENT);
               held_count = 2'd0;
               decode_plain(c, last);
            end
         end
         2'd2: begin
            held_count = 2'd0;
            if (is_hex_char(c) && is_hex_char(held_char)) begin
               decoded_run.push_back({hex_nibble(held_char), hex_nibble(c)});
            end else begin
               decoded_run.push_back(CHAR_PERCENT);
               decode_plain(held_char, 1'b0);
               decode_plain(c, last);
            end
         end
         default: begin
            held_count = 2'd0;
            decode_plain(c, last);
         end
      endcase
      if (last) begin
         held_count = 2'd0;
         held_char  = 8'd0;
      end
      foreach (decoded_run[k]) begin
         entry.data       = decoded_run[k];
         entry.run_last   = (k == decoded_run.size() - 1);
         entry.string_end = entry.run_last && last;
         expected_bytes.push_back(entry);
      end
   endfunction

   task automatic push_beat(input logic [7:0] text, input logic last, input bit hold);
      text_beat_type beat;
      beat.text               = text;
      beat.last               = last;
      beat.hold_until_drained = hold;
      pending_beats.push_back(beat);
      beats_queued++;
   endtask

   task automatic add_text(input string s, input bit hold);
      for (int i = 0; i < s.len(); i++) begin
         push_beat(s[i], i == s.len() - 1, hold && i == 0);
      end
   endtask

   function automatic logic [7:0] random_hex_char();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) begin
         return 8'(CHAR_0 + v);
      end else if ($urandom_range(0, 1) == 0) begin
         return 8'(CHAR_UPPER_A + v - 10);
      end
      return 8'(CHAR_LOWER_A + v - 10);
   endfunction

   function automatic logic [7:0] random_non_hex_char();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(1, 255));
      end while (is_hex_char(c));
      return c;
   endfunction

   // Random bytes, plus signs and well-formed escapes with random content, plus broken and stray ones.
   task automatic add_random_string();
      logic [7:0] chars[$];
      logic [7:0] c;
      bit         hold;
      repeat ($urandom_range(1, 6)) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               c = 8'($urandom_range(1, 255));
               chars.push_back(c);
            end
            3: chars.push_back(CHAR_PLUS);
            4, 5, 6: begin
               chars.push_back(CHAR_PERCENT);
               chars.push_back(random_hex_char());
               chars.push_back(random_hex_char());
            end
            7: begin
               chars.push_back(CHAR_PERCENT);
               chars.push_back(random_non_hex_char());
            end
            8: begin
               chars.push_back(CHAR_PERCENT);
               chars.push_back(random_hex_char());
               chars.push_back(random_non_hex_char());
            end
            default: chars.push_back(CHAR_PERCENT);
         endcase
      end
      hold = ($urandom_range(0, 9) == 0);
      foreach (chars[i]) begin
         push_beat(chars[i], i == chars.size() - 1, hold && i == 0);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (beats_done != beats_queued || expected_bytes.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Request driver: a beat is held until the block takes it.
   always @(negedge clock) begin
      text_beat_type beat;
      logic          next_valid;
      next_valid = req_valid;
      if (!reset && !(req_valid && !req_taken)) begin
         next_valid = 1'b0;
         if (req_gap > 0) begin
            req_gap = req_gap - 1;
         end else if (bursts_on && $urandom_range(0, 7) == 0) begin
            req_gap = $urandom_range(1, 17) - 1;
         end else if (pending_beats.size() > 0 &&
                      !(pending_beats[0].hold_until_drained && expected_bytes.size() > 0)) begin
            beat = pending_beats.pop_front();
            next_valid = 1'b1;
            req_in_byte <= beat.text;
            req_in_last <= beat.last;
         end
      end
      req_valid <= next_valid;
   end

   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_gap = rsp_gap - 1;
         rsp_stall <= 1'b1;
      end else if (bursts_on && $urandom_range(0, 5) == 0) begin
         rsp_gap = $urandom_range(1, 17) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: predict on each accepted request beat, then check result beats.
   always @(posedge clock) begin
      decoded_byte_type want;
      if (reset) begin
         req_taken   <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            predict_decode(req_in_byte, req_in_last);
            beats_done <= beats_done + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               failures++;
               $display("%0t: unexpected result, expected none, got byte %h", $time,
                        rsp_out_byte);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.data) begin
                  failures++;
                  $display("%0t: rsp_out_byte expected %h, got %h", $time, want.data,
                           rsp_out_byte);
               end
               if (rsp_run_last !== want.run_last) begin
                  failures++;
                  $display("%0t: rsp_run_last expected %b, got %b", $time, want.run_last,
                           rsp_run_last);
               end
               if (rsp_string_end !== want.string_end) begin
                  failures++;
                  $display("%0t: rsp_string_end expected %b, got %b", $time, want.string_end,
                           rsp_string_end);
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Zero byte, plus sign, both hex cases, broken and unfinished escapes.
      add_text("%00+", 1'b0);
      add_text("%Ff%aB", 1'b0);
      add_text("%%", 1'b0);
      add_text("%4%41", 1'b0);
      add_text("%", 1'b0);
      add_text("%7", 1'b0);
      push_beat(8'h01, 1'b0, 1'b0);
      push_beat(8'hFF, 1'b1, 1'b0);
      add_text("%4+", 1'b1);

      while (beats_queued < BURST_BEATS) begin
         add_random_string();
      end
      wait_drained();

      // Closing stretch at full rate on both sides.
      bursts_on = 1'b0;
      while (beats_queued < TOTAL_BEATS) begin
         add_random_string();
      end
      wait_drained();
      repeat (8) @(negedge clock);

      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/fud_pkg.sv
rtl/fud_front.sv
rtl/fud_queue.sv
rtl/fud_back.sv
rtl/form_url_decoder_unit.sv
rtl/fud_checker.sv
test/form_url_decoder_unit_test.sv
